@@ rtl/core/i2c_bit_level_master_assert.svh @@
// Assertion macros for the I2C bit-level master checker.
// Include guarded; used by files that write concurrent assertions.
`ifndef I2C_BIT_LEVEL_MASTER_ASSERT_SVH
`define I2C_BIT_LEVEL_MASTER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset
`define I2CBLM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset
`define I2CBLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/i2cblm_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, command codes and the reset value of the I2C bit-level master.
// No dependencies; used by the channel interfaces and the top level.
package i2cblm_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned BYTE_W = 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_IDLE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WAIT  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_ACK   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NACK  = 3'd7;

  // Sub-phases of one bit
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_POLL   = 2'd2;

  localparam logic [BYTE_W-1:0] ACK_TIMEOUT_RST = 8'd250;
  localparam logic [3:0]        BITS_PER_BYTE   = 4'd8;

endpackage

@@ rtl/core/i2cblm_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces of the I2C bit-level master: tick request, result, config write.
// Depends on i2cblm_pkg for field widths.
interface i2cblm_req_if import i2cblm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] write_byte;
  logic              send_ack;
  logic              sda_in;

  modport source (output valid, command, write_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, command, write_byte, send_ack, sda_in, output ready);
endinterface

interface i2cblm_res_if import i2cblm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              scl_level;
  logic              sda_level;
  logic              sda_drive;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] read_data;
  logic              ack_failed;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_data, ack_failed, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_data, ack_failed, output ready);
endinterface

interface i2cblm_cfg_if import i2cblm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/i2c_bit_level_master.sv @@
`timescale 1ns / 1ps
// I2C bit-level master: one request is one bus tick, one result per request.
// Depends on i2cblm_pkg and the channel interfaces in i2cblm_if.sv.
//
// Each accepted request advances the bus sequencer by one tick and yields exactly
// one result with the SCL/SDA levels for that tick, busy, done, the last read byte
// and the ACK-timeout flag. A request is taken every clock cycle: the sequencer
// step is one level of logic from the request port into the result register, and
// a new request is accepted whenever the result register is empty or its result
// is taken in the same cycle. The result is valid in the cycle after acceptance.
// Commands are only picked up while no sequence is running; the ACK timeout
// register is written through the config channel, which is always ready.
module i2c_bit_level_master import i2cblm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  i2cblm_req_if.sink   req_i,
  i2cblm_cfg_if.sink   cfg_i,
  i2cblm_res_if.source res_o
);

  // Sequencer state
  logic [CMD_W-1:0]  act_q, act_d;
  logic [3:0]        bit_q, bit_d;
  logic [1:0]        phase_q, phase_d;
  logic [BYTE_W-1:0] shift_q, shift_d;
  logic [BYTE_W-1:0] poll_q, poll_d;
  logic              ackc_q, ackc_d;
  logic              saf_q, saf_d;
  logic [BYTE_W-1:0] rd_q, rd_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              drv_q, drv_d;
  logic [BYTE_W-1:0] timeout_q;

  // Working values after a possible command load
  logic              load;
  logic [CMD_W-1:0]  cur_act;
  logic [3:0]        cur_bit;
  logic [1:0]        cur_phase;
  logic [BYTE_W-1:0] cur_shift;
  logic [BYTE_W-1:0] cur_poll;
  logic              cur_ackc;
  logic              cur_saf;
  logic [3:0]        bit_inc;
  logic              msb;
  logic              ack_lvl;

  // Tick levels and completion
  logic tick_scl, tick_sda, tick_drv;
  logic fin, fin_scl, fin_sda, fin_drv, fail;

  // Result register
  logic              out_valid_q;
  logic              res_scl_q, res_sda_q, res_drv_q, res_busy_q, res_done_q, res_fail_q;
  logic [BYTE_W-1:0] res_rd_q;
  logic              req_acc;

  assign req_i.ready = !out_valid_q || res_o.ready;
  assign req_acc     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // Pick up a new command on an idle tick
  always_comb begin
    load      = (act_q == CMD_IDLE) && (req_i.command != CMD_IDLE);
    cur_act   = load ? req_i.command : act_q;
    cur_bit   = load ? 4'd0 : bit_q;
    cur_phase = load ? PH_FIRST : phase_q;
    cur_shift = load ? ((req_i.command == CMD_WRITE) ? req_i.write_byte : '0) : shift_q;
    cur_poll  = load ? '0 : poll_q;
    cur_ackc  = load ? req_i.send_ack : ackc_q;
    cur_saf   = load ? 1'b0 : saf_q;
    bit_inc   = cur_bit + 4'd1;
    msb       = cur_shift[BYTE_W-1];
    ack_lvl   = !cur_ackc;
  end

  // One sequencer step
  always_comb begin
    act_d    = cur_act;
    bit_d    = cur_bit;
    phase_d  = cur_phase;
    shift_d  = cur_shift;
    poll_d   = cur_poll;
    ackc_d   = cur_ackc;
    saf_d    = cur_saf;
    rd_d     = rd_q;
    tick_scl = scl_q;
    tick_sda = sda_q;
    tick_drv = drv_q;
    fin      = 1'b0;
    fin_scl  = scl_q;
    fin_sda  = sda_q;
    fin_drv  = drv_q;
    fail     = 1'b0;

    unique case (cur_act)
      CMD_START: begin
        if (cur_phase == PH_FIRST) begin
          tick_scl = 1'b1; tick_sda = 1'b1; tick_drv = 1'b1; phase_d = PH_SECOND;
        end else begin
          tick_scl = 1'b1; tick_sda = 1'b0; tick_drv = 1'b1;
          fin = 1'b1; fin_scl = 1'b0; fin_sda = 1'b0; fin_drv = 1'b1;
        end
      end
      CMD_STOP: begin
        if (cur_phase == PH_FIRST) begin
          tick_scl = 1'b0; tick_sda = 1'b0; tick_drv = 1'b1; phase_d = PH_SECOND;
        end else begin
          tick_scl = 1'b1; tick_sda = 1'b1; tick_drv = 1'b1;
          fin = 1'b1; fin_scl = 1'b1; fin_sda = 1'b1; fin_drv = 1'b1;
        end
      end
      CMD_WRITE: begin
        tick_sda = msb;
        tick_drv = 1'b1;
        if (cur_phase == PH_FIRST) begin
          tick_scl = 1'b1; phase_d = PH_SECOND;
        end else begin
          tick_scl = 1'b0;
          phase_d  = PH_FIRST;
          shift_d  = {cur_shift[BYTE_W-2:0], 1'b0};
          bit_d    = bit_inc;
          if (bit_inc >= BITS_PER_BYTE) begin
            fin = 1'b1; fin_scl = 1'b0; fin_sda = msb; fin_drv = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (cur_bit < BITS_PER_BYTE) begin
          // Data bits: SDA released, sample on SCL high
          tick_sda = 1'b1;
          tick_drv = 1'b0;
          if (cur_phase == PH_FIRST) begin
            tick_scl = 1'b0; phase_d = PH_SECOND;
          end else begin
            tick_scl = 1'b1;
            phase_d  = PH_FIRST;
            shift_d  = {cur_shift[BYTE_W-2:0], req_i.sda_in};
            bit_d    = bit_inc;
            if (bit_inc == BITS_PER_BYTE) rd_d = {cur_shift[BYTE_W-2:0], req_i.sda_in};
          end
        end else begin
          // ACK or NACK after the byte
          tick_sda = ack_lvl;
          tick_drv = 1'b1;
          if (cur_phase == PH_FIRST) begin
            tick_scl = 1'b0; phase_d = PH_SECOND;
          end else begin
            tick_scl = 1'b1;
            fin = 1'b1; fin_scl = 1'b0; fin_sda = ack_lvl; fin_drv = 1'b1;
          end
        end
      end
      CMD_WAIT: begin
        if (cur_saf) begin
          // Stop after a timed-out wait
          tick_drv = 1'b1;
          if (cur_phase == PH_FIRST) begin
            tick_scl = 1'b0; tick_sda = 1'b0; phase_d = PH_SECOND;
          end else begin
            tick_scl = 1'b1; tick_sda = 1'b1; fail = 1'b1;
            fin = 1'b1; fin_scl = 1'b1; fin_sda = 1'b1; fin_drv = 1'b1;
          end
        end else begin
          tick_sda = 1'b1;
          tick_drv = 1'b0;
          if (cur_phase == PH_FIRST) begin
            tick_scl = 1'b0; phase_d = PH_SECOND;
          end else if (cur_phase == PH_SECOND) begin
            tick_scl = 1'b1; phase_d = PH_POLL;
          end else begin
            tick_scl = 1'b1;
            if (!req_i.sda_in) begin
              fin = 1'b1; fin_scl = 1'b0; fin_sda = 1'b1; fin_drv = 1'b0;
            end else if (cur_poll >= timeout_q) begin
              saf_d = 1'b1; phase_d = PH_FIRST;
            end else begin
              poll_d = cur_poll + 8'd1;
            end
          end
        end
      end
      CMD_ACK, CMD_NACK: begin
        tick_sda = (cur_act == CMD_NACK);
        tick_drv = 1'b1;
        if (cur_phase == PH_FIRST) begin
          tick_scl = 1'b0; phase_d = PH_SECOND;
        end else begin
          tick_scl = 1'b1;
          fin = 1'b1; fin_scl = 1'b0; fin_sda = (cur_act == CMD_NACK); fin_drv = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Hold line levels, or take the end-of-sequence levels
    scl_d = scl_q;
    sda_d = sda_q;
    drv_d = drv_q;
    if (fin) begin
      act_d = CMD_IDLE;
      scl_d = fin_scl;
      sda_d = fin_drv ? fin_sda : 1'b1;
      drv_d = fin_drv;
    end
  end

  // Advance the sequencer on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= CMD_IDLE;
      bit_q   <= '0;
      phase_q <= PH_FIRST;
      shift_q <= '0;
      poll_q  <= '0;
      ackc_q  <= 1'b0;
      saf_q   <= 1'b0;
      rd_q    <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drv_q   <= 1'b1;
    end else if (req_acc) begin
      act_q   <= act_d;
      bit_q   <= bit_d;
      phase_q <= phase_d;
      shift_q <= shift_d;
      poll_q  <= poll_d;
      ackc_q  <= ackc_d;
      saf_q   <= saf_d;
      rd_q    <= rd_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      drv_q   <= drv_d;
    end
  end

  // Timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= ACK_TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      timeout_q <= cfg_i.data;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_acc) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      res_scl_q  <= tick_scl;
      res_sda_q  <= tick_drv ? tick_sda : 1'b1;
      res_drv_q  <= tick_drv;
      res_busy_q <= (act_d != CMD_IDLE);
      res_done_q <= fin;
      res_rd_q   <= rd_d;
      res_fail_q <= fin && fail;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.scl_level  = res_scl_q;
  assign res_o.sda_level  = res_sda_q;
  assign res_o.sda_drive  = res_drv_q;
  assign res_o.busy_res   = res_busy_q;
  assign res_o.done_res   = res_done_q;
  assign res_o.read_data  = res_rd_q;
  assign res_o.ack_failed = res_fail_q;

endmodule

@@ rtl/core/i2cblm_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the I2C bit-level master, bound to the top level.
// Depends on the assertion macros in i2c_bit_level_master_assert.svh.
`include "i2c_bit_level_master_assert.svh"

module i2cblm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       scl_level_i,
  input logic       sda_level_i,
  input logic       sda_drive_i,
  input logic       busy_res_i,
  input logic       done_res_i,
  input logic [7:0] read_data_i,
  input logic       ack_failed_i
);

  // A failed ACK wait is only reported with completion
  `I2CBLM_ASSERT_NOW(a_fail_with_done, res_valid_i && ack_failed_i, done_res_i, "ack_failed without done_res")

  // A completed sequence leaves the master idle
  `I2CBLM_ASSERT_NOW(a_done_not_busy, res_valid_i && done_res_i, !busy_res_i, "done_res with busy_res")

  // Released SDA reads as high
  `I2CBLM_ASSERT_NOW(a_release_high, res_valid_i && !sda_drive_i, sda_level_i, "sda_level low while released")

  // Hold a stalled result
  `I2CBLM_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable({scl_level_i, sda_level_i, sda_drive_i, busy_res_i, done_res_i, read_data_i, ack_failed_i}), "stalled result changed")

endmodule

bind i2c_bit_level_master i2cblm_checker u_i2cblm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .scl_level_i  (res_o.scl_level),
  .sda_level_i  (res_o.sda_level),
  .sda_drive_i  (res_o.sda_drive),
  .busy_res_i   (res_o.busy_res),
  .done_res_i   (res_o.done_res),
  .read_data_i  (res_o.read_data),
  .ack_failed_i (res_o.ack_failed)
);
